/* rtl/ghst_pkg.sv */
package ghst_pkg;

    localparam int CAPACITY     = 64;
    localparam int SLOT_W       = $clog2(CAPACITY);
    localparam int SLOT_FIELD_W = 8;
    localparam int WORD_W       = 64;
    localparam int GEN_W        = WORD_W - SLOT_FIELD_W;
    // an entry keeps only the generation part of its handle, the slot part is its address
    localparam int ENTRY_W      = GEN_W + WORD_W;

    typedef enum logic [2:0] {
        FN_STORE_SLOT     = 3'd0,
        FN_STORE_GEN      = 3'd1,
        FN_LOOKUP         = 3'd2,
        FN_RELEASE        = 3'd3,
        FN_INVALIDATE_ALL = 3'd4
    } func_t;

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } state_t;

    typedef struct packed {
        logic [2:0]              func;
        logic [SLOT_FIELD_W-1:0] slot_index;
        logic [WORD_W-1:0]       handle_in;
        logic [WORD_W-1:0]       job_word;
    } req_t;

    typedef struct packed {
        logic              ok;
        logic [WORD_W-1:0] handle_out;
        logic [WORD_W-1:0] job_out;
    } result_t;

    typedef struct packed {
        logic               wr_en;
        logic [SLOT_W-1:0]  wr_addr;
        logic [ENTRY_W-1:0] wr_data;
        logic               rd_en;
        logic [SLOT_W-1:0]  rd_addr;
    } ram_req_t;

endpackage

/* rtl/generation_tagged_slot_table_top.sv */
// Generational handle table: requests enter on the s_ group, one result per request leaves on
// the m_ group through an output register. Store at slot, store generated, invalidate all and
// unknown codes answer in the accepting cycle, so they can stream at one transfer per cycle
// while the output is taken; lookup and release wait on the synchronous read of the entry
// RAM that holds each entry's generation tag and payload. Valid marks live in flip-flops and are
// cleared at once by reset or invalidate all, so no clearing pass is needed after reset.
module generation_tagged_slot_table_top (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [135:0] s_tdata,   // slot_index[7:0], handle_in[71:8], job_word[135:72]
    input  logic [2:0]   s_tuser,   // func[2:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [135:0] m_tdata    // ok[0], handle_out[64:1], job_out[128:65], zero pad
);

    ghst_pkg::req_t    req;
    ghst_pkg::result_t res;
    ghst_pkg::ram_req_t ram_req;
    logic [ghst_pkg::ENTRY_W-1:0] ram_rd_data;
    logic res_valid;
    logic out_free;

    logic         m_tvalid_reg, m_tvalid_next;
    logic [135:0] m_tdata_reg;

    assign req.func       = s_tuser;
    assign req.slot_index = s_tdata[7:0];
    assign req.handle_in  = s_tdata[71:8];
    assign req.job_word   = s_tdata[135:72];

    // output register frees up in the same cycle its transfer completes
    assign out_free = !m_tvalid_reg || m_tready;

    ghst_ram #(
        .WIDTH (ghst_pkg::ENTRY_W),
        .DEPTH (ghst_pkg::CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_req.wr_en),
        .wr_addr (ram_req.wr_addr),
        .wr_data (ram_req.wr_data),
        .rd_en   (ram_req.rd_en),
        .rd_addr (ram_req.rd_addr),
        .rd_data (ram_rd_data)
    );

    ghst_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .req         (req),
        .out_free    (out_free),
        .res_valid   (res_valid),
        .res         (res),
        .ram_req     (ram_req),
        .ram_rd_data (ram_rd_data)
    );

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (res_valid)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            m_tdata_reg <= {7'b0, res.job_out, res.handle_out, res.ok};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

/* rtl/ghst_ram.sv */
module ghst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/ghst_core.sv */
module ghst_core (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  ghst_pkg::req_t           req,
    input  logic                     out_free,
    output logic                     res_valid,
    output ghst_pkg::result_t        res,
    output ghst_pkg::ram_req_t       ram_req,
    input  logic [ghst_pkg::ENTRY_W-1:0] ram_rd_data
);

    localparam int SW = ghst_pkg::SLOT_W;
    localparam int FW = ghst_pkg::SLOT_FIELD_W;
    localparam int GW = ghst_pkg::GEN_W;
    localparam int WW = ghst_pkg::WORD_W;

    ghst_pkg::state_t state_reg, state_next;
    logic [ghst_pkg::CAPACITY-1:0] valid_reg, valid_next;
    logic [SW-1:0]                 rr_reg, rr_next;
    logic [GW-1:0]                 gen_reg, gen_next;
    logic [WW-1:0]                 hold_handle_reg, hold_handle_next;
    logic                          hold_ok_reg, hold_ok_next;
    logic                          hold_rel_reg, hold_rel_next;

    logic          accept;
    logic [GW-1:0] gen_inc;
    logic [GW-1:0] gen_adv;
    logic          slot_in_range;
    logic          handle_usable;
    logic [SW-1:0] hold_idx;
    logic          hit;

    assign in_ready = (state_reg == ghst_pkg::ST_IDLE) && out_free;
    assign accept  = in_valid && in_ready;
    assign gen_inc = gen_reg + GW'(1);
    // wrap skips generation zero
    assign gen_adv = (gen_inc == '0) ? GW'(1) : gen_inc;

    assign slot_in_range = {1'b0, req.slot_index} < (FW + 1)'(ghst_pkg::CAPACITY);
    assign handle_usable = (req.handle_in != '0)
        && ({1'b0, req.handle_in[FW-1:0]} < (FW + 1)'(ghst_pkg::CAPACITY));

    assign hold_idx = hold_handle_reg[SW-1:0];
    assign hit = hold_ok_reg && valid_reg[hold_idx]
        && (ram_rd_data[ghst_pkg::ENTRY_W-1:WW] == hold_handle_reg[WW-1:FW]);

    always_comb
    begin
        state_next       = state_reg;
        valid_next       = valid_reg;
        rr_next          = rr_reg;
        gen_next         = gen_reg;
        hold_handle_next = hold_handle_reg;
        hold_ok_next     = hold_ok_reg;
        hold_rel_next    = hold_rel_reg;
        res_valid        = 1'b0;
        res              = '0;
        ram_req          = '0;

        unique case (state_reg)
            ghst_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (req.func)
                        ghst_pkg::FN_STORE_SLOT:
                        begin
                            res_valid = 1'b1;
                            if (slot_in_range)
                            begin
                                ram_req.wr_en   = 1'b1;
                                ram_req.wr_addr = req.slot_index[SW-1:0];
                                ram_req.wr_data = {GW'(0), req.job_word};
                                valid_next[req.slot_index[SW-1:0]] = 1'b1;
                                res.ok         = 1'b1;
                                res.handle_out = WW'(req.slot_index);
                            end
                        end
                        ghst_pkg::FN_STORE_GEN:
                        begin
                            res_valid       = 1'b1;
                            ram_req.wr_en   = 1'b1;
                            ram_req.wr_addr = rr_reg;
                            ram_req.wr_data = {gen_reg, req.job_word};
                            valid_next[rr_reg] = 1'b1;
                            rr_next  = (rr_reg == SW'(ghst_pkg::CAPACITY - 1))
                                ? '0 : rr_reg + SW'(1);
                            gen_next = gen_adv;
                            res.ok         = 1'b1;
                            res.handle_out = {gen_reg, FW'(rr_reg)};
                        end
                        ghst_pkg::FN_LOOKUP, ghst_pkg::FN_RELEASE:
                        begin
                            ram_req.rd_en    = 1'b1;
                            ram_req.rd_addr  = req.handle_in[SW-1:0];
                            hold_handle_next = req.handle_in;
                            hold_ok_next     = handle_usable;
                            hold_rel_next    = (req.func == ghst_pkg::FN_RELEASE);
                            state_next       = ghst_pkg::ST_READ;
                        end
                        ghst_pkg::FN_INVALIDATE_ALL:
                        begin
                            res_valid  = 1'b1;
                            valid_next = '0;
                            rr_next    = '0;
                            gen_next   = gen_adv;
                            res.ok     = 1'b1;
                        end
                        default:
                        begin
                            res_valid = 1'b1;
                        end
                    endcase
                end
            end
            ghst_pkg::ST_READ:
            begin
                // entry data is held in the ram output until the result can go out
                if (out_free)
                begin
                    res_valid = 1'b1;
                    res.ok    = hit;
                    if (hit && hold_rel_reg)
                    begin
                        valid_next[hold_idx] = 1'b0;
                    end
                    if (hit && !hold_rel_reg)
                    begin
                        res.job_out = ram_rd_data[WW-1:0];
                    end
                    state_next = ghst_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ghst_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ghst_pkg::ST_IDLE;
            valid_reg <= '0;
            rr_reg    <= '0;
            gen_reg   <= GW'(1);
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            rr_reg    <= rr_next;
            gen_reg   <= gen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_handle_reg <= hold_handle_next;
        hold_ok_reg     <= hold_ok_next;
        hold_rel_reg    <= hold_rel_next;
    end

`ifndef ASSERT_OFF
    a_res_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> out_free)
        else $error("result produced while output register is occupied");

    a_read_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req.func == ghst_pkg::FN_LOOKUP || req.func == ghst_pkg::FN_RELEASE))
        |=> (state_reg == ghst_pkg::ST_READ))
        else $error("lookup or release did not wait for the entry read");

    a_immediate: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.func != ghst_pkg::FN_LOOKUP && req.func != ghst_pkg::FN_RELEASE)
        |-> res_valid)
        else $error("immediate request produced no result");

    a_gen_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        gen_reg != '0)
        else $error("generation counter reached zero");

    a_rr_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, rr_reg} < (SW + 1)'(ghst_pkg::CAPACITY))
        else $error("round robin slot beyond capacity");
`endif

endmodule
